// ----- src/wgm_pkg.sv -----
// Package for the wildcard glob matcher: sizes, codes, characters and transfer structs.
package wgm_pkg;

  localparam int PAT_MAX = 64;
  localparam int NPOS    = PAT_MAX + 1;
  localparam int LEN_W   = $clog2(PAT_MAX + 1);
  localparam int LVLS    = $clog2(NPOS);

  localparam logic [1:0] CMD_PATTERN = 2'd0;
  localparam logic [1:0] CMD_TEXT    = 2'd1;
  localparam logic [1:0] CMD_FINISH  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_ORDER    = 2'd2;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic       matched;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic       advance;
    logic       clear;
    logic [7:0] text_char;
  } cell_ctrl_t;

endpackage

// ----- src/wildcard_glob_matcher.sv -----
// Top level of the streaming glob matcher ('?' one byte, '*' any run).
//
//   channel | direction | payload     | transfer when
//   in      | input     | in_item_t   | in_valid && !in_stall
//   out     | output    | out_item_t  | out_valid && !out_stall
//
// One item per cycle while in is not stalled; every command acts on the cell row in the cycle of its transfer.
// A finish result is registered in the result buffer and appears on out once the results ahead of it have left.
// in stalls only while two results wait in the output buffer.
// Reset is synchronous; the pattern store needs no clearing pass.
module wildcard_glob_matcher (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  wgm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wgm_pkg::out_item_t out_data
);
  import wgm_pkg::*;

  logic [LEN_W-1:0]   len;
  logic               text_begun;
  logic [1:0]         fault;
  logic               live_end;

  logic               acc;
  logic               is_pat;
  logic               is_text;
  logic               is_fin;
  logic               store;
  logic [PAT_MAX-1:0] load;
  logic [PAT_MAX-1:0] act;
  logic [PAT_MAX-1:0] prop;
  logic [PAT_MAX-1:0] cell_live;
  logic [PAT_MAX:0]   step;
  logic [NPOS-1:0]    live;
  logic [NPOS-1:0]    closed;
  cell_ctrl_t         ctrl;
  out_item_t          result;

  assign acc     = in_valid & ~in_stall;
  assign is_pat  = acc & (in_data.cmd == CMD_PATTERN);
  assign is_text = acc & (in_data.cmd == CMD_TEXT);
  assign is_fin  = acc & (in_data.cmd == CMD_FINISH);
  assign store   = is_pat & ~text_begun & (len != LEN_W'(PAT_MAX));

  assign ctrl.advance   = is_text;
  assign ctrl.clear     = is_fin;
  assign ctrl.text_char = in_data.character;

  assign step[0] = 1'b0;
  assign live    = {live_end, cell_live};

  for (genvar i = 0; i < PAT_MAX; i++) begin : g_cell
    assign act[i]  = (len > LEN_W'(i));
    assign load[i] = store & (len == LEN_W'(i));

    wgm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .live_init (i == 0),
      .load      (load[i]),
      .load_char (in_data.character),
      .ctrl      (ctrl),
      .act       (act[i]),
      .closed_in (closed[i]),
      .step_in   (step[i]),
      .step_out  (step[i+1]),
      .live      (cell_live[i]),
      .prop      (prop[i])
    );
  end

  wgm_closure u_closure (
    .live   (live),
    .prop   (prop),
    .closed (closed)
  );

  assign result.matched = closed[len];
  assign result.status  = fault;

  always_ff @(posedge clk) begin
    if (rst || is_fin) begin
      len        <= '0;
      text_begun <= 1'b0;
      fault      <= ST_OK;
      live_end   <= 1'b0;
    end else begin
      if (store) begin
        len <= len + LEN_W'(1);
      end
      if (is_pat && fault == ST_OK) begin
        if (text_begun) begin
          fault <= ST_ORDER;
        end else if (len == LEN_W'(PAT_MAX)) begin
          fault <= ST_OVERFLOW;
        end
      end
      if (is_text) begin
        text_begun <= 1'b1;
        live_end   <= step[PAT_MAX];
      end
    end
  end

  wgm_rbuf u_rbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (is_fin),
    .push_item (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- src/wgm_cell.sv -----
// One pattern position: stored character, live bit and step to the next position.
module wgm_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              live_init,
  input  logic              load,
  input  logic [7:0]        load_char,
  input  wgm_pkg::cell_ctrl_t ctrl,
  input  logic              act,
  input  logic              closed_in,
  input  logic              step_in,
  output logic              step_out,
  output logic              live,
  output logic              prop
);
  import wgm_pkg::*;

  logic [7:0] pat;
  logic       is_star;
  logic       hit;

  assign is_star  = (pat == STAR_CHAR);
  assign hit      = (pat == ANY_CHAR) || (pat == ctrl.text_char);
  assign prop     = act & is_star;
  assign step_out = closed_in & act & ~is_star & hit;

  always_ff @(posedge clk) begin
    if (load) begin
      pat <= load_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      live <= live_init;
    end else if (ctrl.advance) begin
      live <= (closed_in & prop) | step_in;
    end
  end

endmodule

// ----- src/wgm_closure.sv -----
// Parallel-prefix empty-run closure of the live set across runs of stars.
module wgm_closure (
  input  logic [wgm_pkg::NPOS-1:0]    live,
  input  logic [wgm_pkg::PAT_MAX-1:0] prop,
  output logic [wgm_pkg::NPOS-1:0]    closed
);
  import wgm_pkg::*;

  logic [NPOS-1:0] g [LVLS+1];
  logic [NPOS-1:0] p [LVLS+1];

  always_comb begin
    g[0] = live;
    p[0] = {prop, 1'b0};
    for (int l = 0; l < LVLS; l++) begin
      for (int j = 0; j < NPOS; j++) begin
        if (j >= (1 << l)) begin
          g[l+1][j] = g[l][j] | (p[l][j] & g[l][j - (1 << l)]);
          p[l+1][j] = p[l][j] & p[l][j - (1 << l)];
        end else begin
          g[l+1][j] = g[l][j];
          p[l+1][j] = p[l][j];
        end
      end
    end
    closed = g[LVLS];
  end

endmodule

// ----- src/wgm_rbuf.sv -----
// Two-entry result buffer between the matcher and the output channel.
module wgm_rbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wgm_pkg::out_item_t  push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output wgm_pkg::out_item_t  out_data
);
  import wgm_pkg::*;

  out_item_t  mem [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/wgm_checker.sv -----
// Port-level checks for the glob matcher and their bind to the top level.
module wgm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input wgm_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input wgm_pkg::out_item_t out_data
);
  import wgm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_OVERFLOW ||
                   out_data.status == ST_ORDER))
    else $error("result status out of range");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.cmd == CMD_FINISH))
    else $error("result without finish transfer");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall) && out_valid)
    else $error("input stalled without waiting results");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for the streaming glob matcher: directed pairs, overflow, random pairs.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wgm_pkg::*;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         WATCHDOG_MAX  = 2000;
  localparam int         SETTLE_CYCLES = 8;
  localparam logic [7:0] LETTER_A      = 8'h61;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent_items     = 0;
  int unsigned fail_count     = 0;

  // Shadow of the matcher state
  logic [7:0]      pat_mem [PAT_MAX];
  int unsigned     pat_len;
  logic [NPOS-1:0] live;
  bit              text_seen;
  logic [1:0]      fault;

  out_item_t pending_verdicts[$];

  wildcard_glob_matcher u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void reset_pair_state();
    live      = '0;
    live[0]   = 1'b1;
    pat_len   = 0;
    text_seen = 1'b0;
    fault     = ST_OK;
  endfunction

  // A live star also enables the position after it; ascending order chains runs of stars.
  function automatic void close_stars();
    for (int i = 0; i < pat_len; i++) begin
      if (live[i] && pat_mem[i] == STAR_CHAR) live[i+1] = 1'b1;
    end
  endfunction

  function automatic bit glob_step(input in_item_t it, output out_item_t verdict);
    logic [NPOS-1:0] nxt;
    nxt     = '0;
    verdict = '0;
    case (it.cmd)
      CMD_PATTERN: begin
        if (text_seen) begin
          if (fault == ST_OK) fault = ST_ORDER;
        end else if (pat_len >= PAT_MAX) begin
          if (fault == ST_OK) fault = ST_OVERFLOW;
        end else begin
          pat_mem[pat_len] = it.character;
          pat_len++;
        end
      end
      CMD_TEXT: begin
        text_seen = 1'b1;
        close_stars();
        for (int i = 0; i < pat_len; i++) begin
          if (live[i]) begin
            if (pat_mem[i] == STAR_CHAR) nxt[i] = 1'b1;
            else if (pat_mem[i] == ANY_CHAR || pat_mem[i] == it.character) nxt[i+1] = 1'b1;
          end
        end
        live = nxt;
      end
      CMD_FINISH: begin
        close_stars();
        verdict.matched = live[pat_len];
        verdict.status  = fault;
        reset_pair_state();
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch);
    in_item_t  it;
    out_item_t verdict;
    it.cmd       = cmd;
    it.character = ch;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (glob_step(it, verdict)) pending_verdicts.push_back(verdict);
    if (cmd != CMD_UNUSED) sent_items++;
  endtask

  task automatic send_chars(input logic [1:0] cmd, input string s);
    for (int i = 0; i < s.len(); i++) send_item(cmd, s[i]);
  endtask

  function automatic logic [7:0] text_char();
    if ($urandom_range(9) == 0) return 8'($urandom);
    return LETTER_A + 8'($urandom_range(2));
  endfunction

  function automatic logic [7:0] pattern_char();
    case ($urandom_range(9))
      0, 1, 2: return text_char();
      3, 4:    return STAR_CHAR;
      5, 6:    return ANY_CHAR;
      7:       return 8'($urandom);
      default: return LETTER_A;
    endcase
  endfunction

  // Mostly texts built to fit the pattern, some perturbed, some unrelated.
  task automatic random_pair();
    logic [7:0]  pat[$];
    logic [7:0]  txt[$];
    int unsigned plen;
    int unsigned pos;
    plen = ($urandom_range(99) < 6) ? $urandom_range(PAT_MAX - 4, PAT_MAX + 3)
                                    : $urandom_range(0, 8);
    repeat (plen) pat.push_back(pattern_char());
    foreach (pat[i]) begin
      if ($urandom_range(99) < 3) send_item(CMD_UNUSED, 8'($urandom));
      send_item(CMD_PATTERN, pat[i]);
    end
    if ($urandom_range(3) != 0) begin
      foreach (pat[i]) begin
        if (i >= PAT_MAX) break;
        if (pat[i] == STAR_CHAR) repeat ($urandom_range(0, 3)) txt.push_back(text_char());
        else if (pat[i] == ANY_CHAR) txt.push_back(8'($urandom));
        else txt.push_back(pat[i]);
      end
      if ($urandom_range(3) == 0) begin
        pos = $urandom_range(txt.size());
        case ($urandom_range(2))
          0: txt.insert(pos, text_char());
          1: if (pos < txt.size()) txt.delete(pos);
          default: if (pos < txt.size()) txt[pos] = txt[pos] ^ 8'h01;
        endcase
      end
    end else begin
      repeat ($urandom_range(0, 10)) txt.push_back(text_char());
    end
    foreach (txt[i]) begin
      if ($urandom_range(99) < 3) send_item(CMD_PATTERN, pattern_char());
      send_item(CMD_TEXT, txt[i]);
    end
    send_item(CMD_FINISH, 8'($urandom));
  endtask

  task automatic test_directed_cases();
    send_item(CMD_FINISH, 8'h00);
    send_item(CMD_TEXT, LETTER_A);
    send_item(CMD_FINISH, 8'hFF);
    send_chars(CMD_PATTERN, "**");
    send_item(CMD_FINISH, 8'h00);
    send_chars(CMD_PATTERN, "a?c");
    send_chars(CMD_TEXT, "abc");
    send_item(CMD_FINISH, 8'h00);
    send_item(CMD_PATTERN, 8'h00);
    send_item(CMD_PATTERN, STAR_CHAR);
    send_item(CMD_PATTERN, 8'hFF);
    send_item(CMD_TEXT, 8'h00);
    send_item(CMD_TEXT, 8'hFF);
    send_item(CMD_FINISH, 8'h00);
    send_item(CMD_PATTERN, ANY_CHAR);
    send_chars(CMD_TEXT, "ab");
    send_item(CMD_FINISH, 8'h00);
    send_item(CMD_UNUSED, 8'hA5);
    send_chars(CMD_PATTERN, "a");
    send_chars(CMD_TEXT, "a");
    send_chars(CMD_PATTERN, "b");
    send_item(CMD_FINISH, 8'h00);
  endtask

  // Exactly full store, then overflow followed by an order fault (first fault wins).
  task automatic test_store_overflow();
    repeat (PAT_MAX) send_item(CMD_PATTERN, ANY_CHAR);
    repeat (PAT_MAX) send_item(CMD_TEXT, 8'($urandom));
    send_item(CMD_FINISH, 8'h00);
    repeat (PAT_MAX + 1) send_item(CMD_PATTERN, STAR_CHAR);
    send_chars(CMD_TEXT, "zz");
    send_chars(CMD_PATTERN, "q");
    send_item(CMD_FINISH, 8'h00);
  endtask

  task automatic test_random_pairs(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned count);
    int unsigned start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = sent_items;
    while (sent_items - start < count) random_pair();
  endtask

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin : check_result
      out_item_t want;
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: unexpected result matched=%0d status=%0d",
                   out_data.matched, out_data.status);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.matched !== want.matched || out_data.status !== want.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: expected matched=%0d status=%0d, got matched=%0d status=%0d",
                     want.matched, want.status, out_data.matched, out_data.status);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_MAX) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    reset_pair_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_store_overflow();
    test_random_pairs(0, 0, 170);
    test_random_pairs(80, 0, 170);
    test_random_pairs(0, 80, 170);
    test_random_pairs(9, 9, 170);

    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/wgm_pkg.sv
src/wgm_cell.sv
src/wgm_closure.sv
src/wgm_rbuf.sv
src/wildcard_glob_matcher.sv
src/wgm_checker.sv
test/tb_top.sv
